// ===== rtl/cts_pkg.sv =====
`timescale 1ns / 1ps
package cts_pkg;
  localparam int PosW = 32;
  localparam int ManW = 64;

  localparam logic [2:0] TT_EOS = 3'd0;
  localparam logic [2:0] TT_NUM = 3'd1;
  localparam logic [2:0] TT_STR = 3'd2;
  localparam logic [2:0] TT_SYM = 3'd3;
  localparam logic [2:0] TT_BOOL = 3'd4;
  localparam logic [2:0] TT_ERR = 3'd5;

  localparam logic [1:0] EK_NONE = 2'd0;
  localparam logic [1:0] EK_NUM = 2'd1;
  localparam logic [1:0] EK_STR = 2'd2;

  typedef struct packed {
    logic [2:0]  token_type;
    logic [1:0]  error_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] token_line;
    logic [31:0] token_column;
    logic        bool_value;
    logic        is_negative;
    logic [63:0] mantissa;
    logic [7:0]  fraction_digits;
    logic [15:0] exponent;
    logic        last;
  } token_t;

  // One scanner step produces at most two tokens.
  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } pair_t;

  function automatic logic is_space(input logic [20:0] c);
    return (c >= 21'h09 && c <= 21'h0D) || c == 21'h20 || c == 21'h85 || c == 21'hA0 ||
           c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) || c == 21'h2028 ||
           c == 21'h2029 || c == 21'h202F || c == 21'h205F || c == 21'h3000;
  endfunction

  function automatic logic is_digit(input logic [20:0] c);
    return c >= 21'h30 && c <= 21'h39;
  endfunction
endpackage

// ===== rtl/codepoint_token_scanner.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload
// s_axis    in   tuser: kind; tdata: codepoint [20:0]
// m_axis    out  tlast: last; tdata: token fields, 223 bits packed, one pad bit
// One codepoint per cycle while s_axis_tready is high; an end-of-source beat
// yields up to two tokens, drained one a cycle while m_axis_tready is high from
// a two-entry queue of token pairs. The scanner step (mode update, multiply by
// ten) writes the queue on acceptance; a token is offered next cycle at earliest.
// rst is synchronous and returns the scanner to the start of a source.
// s_axis_tready drops only while the queue is full and not draining.
module codepoint_token_scanner (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // codepoint [20:0]
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // token_type, error_kind, start_offset, token_length, token_line,
  // token_column, bool_value, is_negative, mantissa, fraction_digits, exponent
  output logic [223:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  logic            push, q_room;
  cts_pkg::pair_t  pd;
  cts_pkg::token_t t;

  cts_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .kind(s_axis_tuser), .cp(s_axis_tdata[20:0]),
    .push, .push_data(pd), .q_room
  );

  cts_back u_back (
    .clk, .rst, .push, .push_data(pd), .q_room,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_tok(t)
  );

  assign m_axis_tdata = {1'b0, t.exponent, t.fraction_digits, t.mantissa, t.is_negative,
                         t.bool_value, t.token_column, t.token_line, t.token_length,
                         t.start_offset, t.error_kind, t.token_type};
  assign m_axis_tlast = t.last;
endmodule

// ===== rtl/cts_front.sv =====
`timescale 1ns / 1ps
module cts_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [20:0]        cp,
  output logic               push,
  output cts_pkg::pair_t     push_data,
  input  logic               q_room
);
  typedef enum logic [3:0] {
    M_IDLE, M_SIGN, M_INT, M_FRAC0, M_FRAC, M_EXP0, M_EXPS, M_EXP, M_SYM, M_STR, M_ESC
  } mode_t;

  mode_t       mode, mode_next;
  logic [31:0] position, cur_line, cur_column, tok_start, tok_line, tok_column;
  logic [31:0] tok_start_next, tok_line_next, tok_column_next;
  logic [63:0] digit_acc, digit_acc_next;
  logic [7:0]  frac_count, frac_count_next;
  logic [15:0] exp_acc, exp_acc_next;
  logic [1:0]  sign_flags, sign_flags_next;
  logic [4:0]  kw, kw_next;

  logic        n_emit;
  logic        n_two;
  cts_pkg::token_t e0, e1;
  logic        fire;

  assign in_ready = q_room;
  assign fire = in_valid && in_ready;

  function automatic logic [63:0] add_dig(input logic [63:0] a, input logic [3:0] d);
    logic [67:0] p;
    p = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {64'd0, d};
    return (p[67:64] != 4'd0) ? '1 : p[63:0];
  endfunction

  function automatic logic [15:0] add_exp(input logic [15:0] a, input logic [3:0] d);
    logic [19:0] p;
    p = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {16'd0, d};
    return (p > 20'd32768) ? 16'h8000 : p[15:0];
  endfunction

  function automatic logic [4:0] feed(input logic [4:0] k, input logic [20:0] c);
    logic [2:0] i;
    logic t, f;
    logic [20:0] tc, fc;
    i = k[4:2];
    case (i)
      3'd0: begin tc = 21'h74; fc = 21'h66; end
      3'd1: begin tc = 21'h72; fc = 21'h61; end
      3'd2: begin tc = 21'h75; fc = 21'h6C; end
      3'd3: begin tc = 21'h65; fc = 21'h73; end
      3'd4: begin tc = 21'h1FFFFF; fc = 21'h65; end
      default: begin tc = 21'h1FFFFF; fc = 21'h1FFFFF; end
    endcase
    t = k[0] && i < 3'd4 && c == tc;
    f = k[1] && i < 3'd5 && c == fc;
    if (i != 3'd7) i = i + 3'd1;
    return {i, f, t};
  endfunction

  function automatic cts_pkg::token_t blank();
    cts_pkg::token_t r;
    r = '0;
    return r;
  endfunction

  always_comb begin
    cts_pkg::token_t num, sym, str, eos;
    logic [1:0] ek;
    logic dig, sp;
    logic [3:0] d;
    logic restart;
    logic [4:0] kws;
    dig = cts_pkg::is_digit(cp);
    sp = cts_pkg::is_space(cp);
    d = cp[3:0];
    restart = 1'b0;
    mode_next = mode;
    tok_start_next = tok_start;
    tok_line_next = tok_line;
    tok_column_next = tok_column;
    digit_acc_next = digit_acc;
    frac_count_next = frac_count;
    exp_acc_next = exp_acc;
    sign_flags_next = sign_flags;
    kw_next = kw;
    n_emit = 1'b0;
    n_two = 1'b0;
    ek = cts_pkg::EK_NUM;

    num = blank();
    num.token_type = cts_pkg::TT_NUM;
    num.token_line = tok_line;
    num.token_column = tok_column;
    num.is_negative = sign_flags[0];
    num.mantissa = digit_acc;
    num.fraction_digits = frac_count;
    num.exponent = sign_flags[1] ? (16'd0 - exp_acc)
                 : (exp_acc[15] ? 16'h7FFF : exp_acc);

    kws = (mode == M_SIGN) ? 5'b00100 : kw;
    sym = blank();
    sym.token_type = cts_pkg::TT_SYM;
    sym.start_offset = tok_start;
    sym.token_length = position - tok_start;
    sym.token_line = tok_line;
    sym.token_column = tok_column;
    if (kws[0] && kws[4:2] == 3'd4) begin
      sym.token_type = cts_pkg::TT_BOOL;
      sym.bool_value = 1'b1;
    end else if (kws[1] && kws[4:2] == 3'd5) begin
      sym.token_type = cts_pkg::TT_BOOL;
    end

    str = sym;
    str.token_type = cts_pkg::TT_STR;
    str.bool_value = 1'b0;

    eos = blank();
    eos.token_line = cur_line;
    eos.token_column = cur_column;

    e0 = num;
    if (kind) begin
      unique case (mode)
        M_SIGN, M_SYM: begin n_emit = 1'b1; e0 = sym; end
        M_INT, M_FRAC, M_EXP: begin n_emit = 1'b1; e0 = num; end
        M_FRAC0, M_EXP0, M_EXPS: n_emit = 1'b1;
        M_STR, M_ESC: begin n_emit = 1'b1; ek = cts_pkg::EK_STR; end
        default: ;
      endcase
      if (!(mode == M_SIGN || mode == M_SYM || mode == M_INT || mode == M_FRAC ||
            mode == M_EXP)) begin
        e0 = eos;
        e0.token_type = cts_pkg::TT_ERR;
        e0.error_kind = ek;
      end
    end else begin
      unique case (mode)
        M_SIGN: begin
          if (dig) begin
            digit_acc_next = add_dig(digit_acc, d);
            mode_next = M_INT;
          end else begin
            sign_flags_next = 2'b00;
            if (sp) begin
              n_emit = 1'b1; e0 = sym; mode_next = M_IDLE; kw_next = 5'b00100;
            end else begin
              kw_next = feed(5'b00100, cp); mode_next = M_SYM;
            end
          end
        end
        M_INT, M_FRAC: begin
          if (dig) begin
            digit_acc_next = add_dig(digit_acc, d);
            if (mode == M_FRAC && frac_count != 8'hFF) frac_count_next = frac_count + 8'd1;
          end else if (cp == 21'h2E && mode == M_INT) mode_next = M_FRAC0;
          else if (cp == 21'h65 || cp == 21'h45) mode_next = M_EXP0;
          else begin n_emit = 1'b1; e0 = num; restart = 1'b1; end
        end
        M_FRAC0: begin
          if (dig) begin
            digit_acc_next = add_dig(digit_acc, d);
            frac_count_next = 8'd1;
            mode_next = M_FRAC;
          end else begin n_emit = 1'b1; e0 = eos; restart = 1'b1; end
        end
        M_EXP0: begin
          if (dig) begin exp_acc_next = add_exp(exp_acc, d); mode_next = M_EXP; end
          else if (cp == 21'h2B || cp == 21'h2D) begin
            if (cp == 21'h2D) sign_flags_next = sign_flags | 2'b10;
            mode_next = M_EXPS;
          end else begin n_emit = 1'b1; e0 = eos; restart = 1'b1; end
        end
        M_EXPS: begin
          if (dig) begin exp_acc_next = add_exp(exp_acc, d); mode_next = M_EXP; end
          else begin n_emit = 1'b1; e0 = eos; restart = 1'b1; end
        end
        M_EXP: begin
          if (dig) exp_acc_next = add_exp(exp_acc, d);
          else begin n_emit = 1'b1; e0 = num; restart = 1'b1; end
        end
        M_SYM: begin
          if (sp) begin n_emit = 1'b1; e0 = sym; mode_next = M_IDLE; end
          else kw_next = feed(kw, cp);
        end
        M_STR: begin
          if (cp == 21'h5C) mode_next = M_ESC;
          else if (cp == 21'h22) begin n_emit = 1'b1; e0 = str; mode_next = M_IDLE; end
        end
        M_ESC: mode_next = M_STR;
        default: restart = 1'b1;
      endcase
      if (n_emit && (mode == M_FRAC0 || mode == M_EXP0 || mode == M_EXPS)) begin
        e0.token_type = cts_pkg::TT_ERR;
        e0.error_kind = cts_pkg::EK_NUM;
      end
      if (restart) begin
        mode_next = M_IDLE;
        if (!sp) begin
          tok_start_next = position;
          tok_line_next = cur_line;
          tok_column_next = cur_column;
          digit_acc_next = '0;
          frac_count_next = '0;
          exp_acc_next = '0;
          sign_flags_next = '0;
          kw_next = 5'b00011;
          if (dig) begin
            digit_acc_next = {60'd0, d};
            mode_next = M_INT;
          end else if (cp == 21'h2B || cp == 21'h2D) begin
            sign_flags_next = {1'b0, cp == 21'h2D};
            mode_next = M_SIGN;
          end else if (cp == 21'h22) begin
            tok_start_next = position + 32'd1;
            mode_next = M_STR;
          end else begin
            kw_next = feed(5'b00011, cp);
            mode_next = M_SYM;
          end
        end
      end
    end
    e1 = eos;
    if (kind) begin
      n_two = n_emit;
      if (!n_emit) e0 = eos;
      n_emit = 1'b1;
    end
    e0.last = !n_two;
    e1.last = 1'b1;
  end

  assign push = fire && n_emit;
  always_comb begin
    push_data.two = n_two;
    push_data.t0 = e0;
    push_data.t1 = e1;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && kind)) begin
      mode <= M_IDLE;
      position <= '0;
      cur_line <= 32'd1;
      cur_column <= 32'd1;
      tok_start <= '0;
      tok_line <= 32'd1;
      tok_column <= 32'd1;
      digit_acc <= '0;
      frac_count <= '0;
      exp_acc <= '0;
      sign_flags <= '0;
      kw <= 5'b00011;
    end else if (fire) begin
      mode <= mode_next;
      position <= position + 32'd1;
      if (cp == 21'h0A) begin
        if (cur_line != '1) cur_line <= cur_line + 32'd1;
        cur_column <= 32'd1;
      end else if (cur_column != '1) begin
        cur_column <= cur_column + 32'd1;
      end
      tok_start <= tok_start_next;
      tok_line <= tok_line_next;
      tok_column <= tok_column_next;
      digit_acc <= digit_acc_next;
      frac_count <= frac_count_next;
      exp_acc <= exp_acc_next;
      sign_flags <= sign_flags_next;
      kw <= kw_next;
    end
  end
endmodule

// ===== rtl/cts_back.sv =====
`timescale 1ns / 1ps
module cts_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cts_pkg::pair_t     push_data,
  output logic               q_room,
  output logic               out_valid,
  input  logic               out_ready,
  output cts_pkg::token_t    out_tok
);
  // Two-entry queue of token pairs; each entry drains one or two beats.
  cts_pkg::pair_t q [2];
  logic       rd, wr;
  logic [1:0] cnt;
  logic       half;
  logic       pop;

  assign q_room = (cnt != 2'd2) || pop;
  assign out_valid = cnt != 2'd0;
  assign out_tok = half ? q[rd].t1 : q[rd].t0;
  assign pop = out_valid && out_ready && (half || !q[rd].two);

  always_ff @(posedge clk) begin
    if (push) q[wr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      cnt <= '0;
      half <= 1'b0;
    end else begin
      if (push) wr <= ~wr;
      if (pop) begin
        rd <= ~rd;
        half <= 1'b0;
      end else if (out_valid && out_ready) begin
        half <= 1'b1;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== tb/token_checker.sv =====
`timescale 1ns / 1ps
module token_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // codepoint [20:0]
  input  logic         s_axis_tuser,   // kind
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [223:0] m_axis_tdata,   // token_type .. exponent, lowest first
  input  logic         m_axis_tlast,
  output int           mismatches,
  output int           tokens_waiting,
  output int           tokens_seen
);
  typedef enum logic [3:0] {
    LM_IDLE, LM_SIGN, LM_INT, LM_FRAC0, LM_FRAC, LM_EXP0, LM_EXPS, LM_EXP,
    LM_SYM, LM_STR, LM_ESC
  } lex_mode_e;

  localparam logic [20:0] CP_LF    = 21'h0A;
  localparam logic [20:0] CP_QUOTE = 21'h22;
  localparam logic [20:0] CP_PLUS  = 21'h2B;
  localparam logic [20:0] CP_MINUS = 21'h2D;
  localparam logic [20:0] CP_DOT   = 21'h2E;
  localparam logic [20:0] CP_ZERO  = 21'h30;
  localparam logic [20:0] CP_NINE  = 21'h39;
  localparam logic [20:0] CP_UE    = 21'h45;
  localparam logic [20:0] CP_BSL   = 21'h5C;
  localparam logic [20:0] CP_LE    = 21'h65;

  lex_mode_e   mode;
  logic [31:0] pos, line, col, tstart, tline, tcol;
  logic [63:0] acc;
  int unsigned fracn, expn, kwlen;
  logic        neg, eneg, kw_t, kw_f;
  cts_pkg::token_t step_toks[$];
  cts_pkg::token_t expected_tokens[$];

  assign tokens_waiting = expected_tokens.size();

  function automatic logic white(input logic [20:0] c);
    return c inside {[21'h09:21'h0D], 21'h20, 21'h85, 21'hA0, 21'h1680,
                     [21'h2000:21'h200A], 21'h2028, 21'h2029, 21'h202F,
                     21'h205F, 21'h3000};
  endfunction

  function automatic logic digit(input logic [20:0] c);
    return c >= CP_ZERO && c <= CP_NINE;
  endfunction

  task automatic restart_source();
    mode = LM_IDLE; pos = 0; line = 1; col = 1; tstart = 0; tline = 1; tcol = 1;
    acc = 0; fracn = 0; expn = 0; neg = 0; eneg = 0; kw_t = 1; kw_f = 1; kwlen = 0;
  endtask

  task automatic begin_token();
    tstart = pos; tline = line; tcol = col;
    acc = 0; fracn = 0; expn = 0; neg = 0; eneg = 0; kw_t = 1; kw_f = 1; kwlen = 0;
  endtask

  task automatic shift_digit(input logic [20:0] c);
    logic [63:0] d;
    d = 64'(c - CP_ZERO);
    if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) acc = 64'hFFFF_FFFF_FFFF_FFFF;
    else acc = acc * 10 + d;
  endtask

  task automatic shift_exp_digit(input logic [20:0] c);
    expn = expn * 10 + int'(c - CP_ZERO);
    if (expn > 32768) expn = 32768;
  endtask

  task automatic emit_number();
    cts_pkg::token_t t;
    t = '0;
    t.token_type = cts_pkg::TT_NUM; t.token_line = tline; t.token_column = tcol;
    t.is_negative = neg; t.mantissa = acc; t.fraction_digits = fracn[7:0];
    if (eneg) t.exponent = 16'(32'd0 - expn);
    else t.exponent = (expn > 32767) ? 16'h7FFF : expn[15:0];
    step_toks.push_back(t);
  endtask

  task automatic emit_error(input logic [1:0] ek);
    cts_pkg::token_t t;
    t = '0;
    t.token_type = cts_pkg::TT_ERR; t.error_kind = ek;
    t.token_line = line; t.token_column = col;
    step_toks.push_back(t);
  endtask

  task automatic emit_symbol();
    cts_pkg::token_t t;
    t = '0;
    t.token_type = cts_pkg::TT_SYM; t.start_offset = tstart; t.token_length = pos - tstart;
    t.token_line = tline; t.token_column = tcol;
    if (kw_t && kwlen == 4) begin
      t.token_type = cts_pkg::TT_BOOL; t.bool_value = 1'b1;
    end else if (kw_f && kwlen == 5) begin
      t.token_type = cts_pkg::TT_BOOL;
    end
    step_toks.push_back(t);
  endtask

  task automatic track_keyword(input logic [20:0] c);
    string tw, fw;
    tw = "true"; fw = "false";
    kw_t = kw_t && kwlen < 4 && c == 21'(tw[kwlen]);
    kw_f = kw_f && kwlen < 5 && c == 21'(fw[kwlen]);
    if (kwlen < 7) kwlen++;
  endtask

  task automatic open_token(input logic [20:0] c);
    if (!white(c)) begin
      begin_token();
      if (digit(c)) begin
        shift_digit(c); mode = LM_INT;
      end else if (c == CP_PLUS || c == CP_MINUS) begin
        neg = (c == CP_MINUS); mode = LM_SIGN;
      end else if (c == CP_QUOTE) begin
        tstart = pos + 1; mode = LM_STR;
      end else begin
        track_keyword(c); mode = LM_SYM;
      end
    end
  endtask

  task automatic scan_codepoint(input logic [20:0] c);
    logic dg;
    dg = digit(c);
    case (mode)
      LM_SIGN: begin
        if (dg) begin
          shift_digit(c); mode = LM_INT;
        end else begin
          // sign with no digit after it starts a symbol; alone, it is one codepoint
          kw_t = 0; kw_f = 0; kwlen = 1; neg = 0; mode = LM_SYM;
          if (white(c)) begin
            emit_symbol(); mode = LM_IDLE;
          end else track_keyword(c);
        end
      end
      LM_INT, LM_FRAC: begin
        if (dg) begin
          shift_digit(c);
          if (mode == LM_FRAC && fracn < 255) fracn++;
        end else if (c == CP_DOT && mode == LM_INT) mode = LM_FRAC0;
        else if (c == CP_LE || c == CP_UE) mode = LM_EXP0;
        else begin
          emit_number(); mode = LM_IDLE; open_token(c);
        end
      end
      LM_FRAC0: begin
        if (dg) begin
          shift_digit(c); fracn = 1; mode = LM_FRAC;
        end else begin
          emit_error(cts_pkg::EK_NUM); mode = LM_IDLE; open_token(c);
        end
      end
      LM_EXP0: begin
        if (dg) begin
          shift_exp_digit(c); mode = LM_EXP;
        end else if (c == CP_PLUS || c == CP_MINUS) begin
          if (c == CP_MINUS) eneg = 1;
          mode = LM_EXPS;
        end else begin
          emit_error(cts_pkg::EK_NUM); mode = LM_IDLE; open_token(c);
        end
      end
      LM_EXPS: begin
        if (dg) begin
          shift_exp_digit(c); mode = LM_EXP;
        end else begin
          emit_error(cts_pkg::EK_NUM); mode = LM_IDLE; open_token(c);
        end
      end
      LM_EXP: begin
        if (dg) shift_exp_digit(c);
        else begin
          emit_number(); mode = LM_IDLE; open_token(c);
        end
      end
      LM_SYM: begin
        if (white(c)) begin
          emit_symbol(); mode = LM_IDLE;
        end else track_keyword(c);
      end
      LM_STR: begin
        if (c == CP_BSL) mode = LM_ESC;
        else if (c == CP_QUOTE) begin
          cts_pkg::token_t t;
          t = '0;
          t.token_type = cts_pkg::TT_STR; t.start_offset = tstart;
          t.token_length = pos - tstart;
          t.token_line = tline; t.token_column = tcol;
          step_toks.push_back(t);
          mode = LM_IDLE;
        end
      end
      LM_ESC: mode = LM_STR;
      default: begin
        mode = LM_IDLE; open_token(c);
      end
    endcase
  endtask

  task automatic scan_end();
    cts_pkg::token_t t;
    case (mode)
      LM_SIGN: begin
        kw_t = 0; kw_f = 0; kwlen = 1; emit_symbol();
      end
      LM_INT, LM_FRAC, LM_EXP: emit_number();
      LM_FRAC0, LM_EXP0, LM_EXPS: emit_error(cts_pkg::EK_NUM);
      LM_SYM: emit_symbol();
      LM_STR, LM_ESC: emit_error(cts_pkg::EK_STR);
      default: ;
    endcase
    t = '0;
    t.token_type = cts_pkg::TT_EOS; t.token_line = line; t.token_column = col;
    step_toks.push_back(t);
  endtask

  task automatic predict_tokens(input logic kind, input logic [20:0] c);
    step_toks.delete();
    if (kind) begin
      scan_end();
      restart_source();
    end else begin
      scan_codepoint(c);
      if (c == CP_LF) begin
        if (line != 32'hFFFF_FFFF) line++;
        col = 1;
      end else if (col != 32'hFFFF_FFFF) col++;
      pos++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endtask

  function automatic cts_pkg::token_t unpack_beat(input logic [223:0] d, input logic lst);
    cts_pkg::token_t t;
    t.token_type      = d[2:0];
    t.error_kind      = d[4:3];
    t.start_offset    = d[36:5];
    t.token_length    = d[68:37];
    t.token_line      = d[100:69];
    t.token_column    = d[132:101];
    t.bool_value      = d[133];
    t.is_negative     = d[134];
    t.mantissa        = d[198:135];
    t.fraction_digits = d[206:199];
    t.exponent        = d[222:207];
    t.last            = lst;
    return t;
  endfunction

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] g,
                             inout logic bad);
    if (g !== e) begin
      if (mismatches < 10)
        $display("%0t mismatch in token %0d: %s expected %0h got %0h",
                 $realtime, tokens_seen, name, e, g);
      bad = 1;
    end
  endtask

  initial begin
    mismatches = 0;
    tokens_seen = 0;
    restart_source();
  end

  always @(posedge clk) begin
    cts_pkg::token_t got, exp_tok;
    logic bad;
    if (!rst) begin
      // compare first: an output beat never belongs to the input beat of the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_beat(m_axis_tdata, m_axis_tlast);
        if (expected_tokens.size() == 0) begin
          if (mismatches < 10) $display("%0t token with nothing expected", $realtime);
          mismatches++;
        end else begin
          exp_tok = expected_tokens.pop_front();
          bad = 0;
          check_field("token_type", 64'(exp_tok.token_type), 64'(got.token_type), bad);
          check_field("error_kind", 64'(exp_tok.error_kind), 64'(got.error_kind), bad);
          check_field("start_offset", 64'(exp_tok.start_offset), 64'(got.start_offset), bad);
          check_field("token_length", 64'(exp_tok.token_length), 64'(got.token_length), bad);
          check_field("token_line", 64'(exp_tok.token_line), 64'(got.token_line), bad);
          check_field("token_column", 64'(exp_tok.token_column), 64'(got.token_column), bad);
          check_field("bool_value", 64'(exp_tok.bool_value), 64'(got.bool_value), bad);
          check_field("is_negative", 64'(exp_tok.is_negative), 64'(got.is_negative), bad);
          check_field("mantissa", exp_tok.mantissa, got.mantissa, bad);
          check_field("fraction_digits", 64'(exp_tok.fraction_digits),
                      64'(got.fraction_digits), bad);
          check_field("exponent", 64'(exp_tok.exponent), 64'(got.exponent), bad);
          check_field("last", 64'(exp_tok.last), 64'(got.last), bad);
          if (bad) mismatches++;
        end
        tokens_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tuser, s_axis_tdata[20:0]);
    end
  end
endmodule

// ===== tb/tb_codepoint_token_scanner.sv =====
`timescale 1ns / 1ps
module tb_codepoint_token_scanner;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic        kind;
    logic [20:0] cp;
  } src_beat_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [223:0] m_axis_tdata;
  logic         m_axis_tlast;

  int        mismatches, tokens_waiting, tokens_seen;
  src_beat_t source[$];
  logic      calm;
  logic      hold_req;
  logic      held;
  int        idle_cycles;
  int        sources_ended;

  codepoint_token_scanner dut (.*);

  token_checker u_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .mismatches, .tokens_waiting, .tokens_seen
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic put(input logic [20:0] c);
    source.push_back('{kind: 1'b0, cp: c});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(21'(s[i]));
  endtask

  task automatic put_end();
    source.push_back('{kind: 1'b1, cp: 21'($urandom_range(0, 21'h1FFFFF))});
    sources_ended++;
  endtask

  task automatic put_digits(input int n);
    for (int i = 0; i < n; i++) put(21'($urandom_range(8'h30, 8'h39)));
  endtask

  task automatic put_separator();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) put(21'h20);
    else if (r < 11) put(21'h0A);
    else if (r < 13) put(21'($urandom_range(9, 13)));
    else if (r < 17) begin
      case ($urandom_range(0, 8))
        0: put(21'h85);
        1: put(21'hA0);
        2: put(21'h1680);
        3: put(21'($urandom_range(21'h2000, 21'h200A)));
        4: put(21'h2028);
        5: put(21'h2029);
        6: put(21'h202F);
        7: put(21'h205F);
        default: put(21'h3000);
      endcase
    end
    // otherwise no separator: tokens run into each other
  endtask

  task automatic put_number();
    int r;
    r = $urandom_range(0, 2);
    if (r == 1) put(21'h2D);
    else if (r == 2) put(21'h2B);
    put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6));
    if ($urandom_range(0, 2) == 0) begin
      put(21'h2E);
      r = $urandom_range(0, 19);
      put_digits(r == 0 ? 0 : (r == 1 ? $urandom_range(250, 270) : $urandom_range(1, 5)));
    end
    if ($urandom_range(0, 2) == 0) begin
      put($urandom_range(0, 1) ? 21'h65 : 21'h45);
      r = $urandom_range(0, 3);
      if (r == 1) put(21'h2D);
      else if (r == 2) put(21'h2B);
      r = $urandom_range(0, 14);
      put_digits(r == 0 ? 0 : (r == 1 ? $urandom_range(5, 7) : $urandom_range(1, 3)));
    end
  endtask

  task automatic put_string();
    int n;
    put(21'h22);
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          put(21'h5C);
          put($urandom_range(0, 1) ? 21'h22 : 21'($urandom_range(21'h20, 21'h7E)));
        end
        1: put(21'($urandom_range(0, 21'h1FFFFF)));
        2: put(21'h0A);
        default: put(21'($urandom_range(21'h61, 21'h7A)));
      endcase
    end
    if ($urandom_range(0, 9) != 0) put(21'h22);
  endtask

  task automatic put_symbol();
    case ($urandom_range(0, 9))
      0: put_text("true");
      1: put_text("false");
      2: put_text("tru");
      3: put_text("falsey");
      4: put_text($urandom_range(0, 1) ? "+" : "-");
      5: put_text("truex");
      6: put(21'($urandom_range(21'h80, 21'h1FFFFF)));
      default: begin
        int n;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) put(21'($urandom_range(21'h21, 21'h7E)));
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // source traffic
  initial begin
    int gap;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    sources_ended = 0;

    // directed: keywords, signed fraction with exponent, escaped quote, broken numbers,
    // lone sign, open string at end, an out-of-range codepoint
    put_text("true false -12.5e+3 \"a\\\"b\" x\n1. 1e- + ");
    put(21'h1FFFFF);
    put_text(" \"ab");
    put_end();

    while (source.size() < 1300) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: put_number();
        4, 5: put_string();
        6, 7: put_symbol();
        8: put(21'($urandom_range(0, 21'h1FFFFF)));
        default: put_separator();
      endcase
      put_separator();
      if ($urandom_range(0, 39) == 0) put_end();
    end
    put_end();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (source[i]) begin
      if (i % 97 == 0) calm = ~calm;
      if (i == 400) hold_req = 1'b1;
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= source[i].kind;
      s_axis_tdata <= {3'b000, source[i].cp};
      do @(negedge clk); while (!s_axis_tready);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;

    while (tokens_waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Scanned %0d codepoint and end beats over %0d sources; %0d tokens checked.",
             source.size(), sources_ended, tokens_seen);
    if (mismatches == 0 && tokens_waiting == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // token sink with random stalls and one long hold-off to fill the block
  initial begin
    m_axis_tready = 1'b0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 149) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) < 70);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end
endmodule

// ===== files.f =====
rtl/cts_pkg.sv
rtl/cts_front.sv
rtl/cts_back.sv
rtl/codepoint_token_scanner.sv
tb/token_checker.sv
tb/tb_codepoint_token_scanner.sv
